// ----- rtl/svpl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position loop package
// Shared types, codes and tuning constants of the servo position loop.
// ----------------------------------------------------------------------------
package svpl_pkg;

	// Pulse mapping and loop tuning constants.
	localparam logic [15:0] PULSE_CENTER_US    = 16'd1500;
	localparam logic [15:0] PULSE_HALF_SPAN_US = 16'd500;
	localparam logic [15:0] PULSE_LO_US        = PULSE_CENTER_US - PULSE_HALF_SPAN_US;
	localparam logic [15:0] PULSE_HI_US        = PULSE_CENTER_US + PULSE_HALF_SPAN_US;
	localparam logic [7:0]  TIMEOUT_TICKS      = 8'd10;
	localparam logic [7:0]  STALE_MAX          = TIMEOUT_TICKS + 8'd1;
	localparam logic [11:0] DUTY_MAX           = 12'd1000;
	localparam logic [11:0] MIN_DUTY           = 12'd300;
	localparam logic [11:0] RAMP_SPAN          = DUTY_MAX - MIN_DUTY;
	localparam logic [11:0] FULL_SCALE         = 12'd1600;
	localparam logic [11:0] GAIN_ROUND         = 12'd500;
	localparam logic [11:0] GAIN_SCALE         = 12'd1000;

	// Drive mode codes.
	localparam logic [1:0] MODE_COAST = 2'd0;
	localparam logic [1:0] MODE_BRAKE = 2'd1;
	localparam logic [1:0] MODE_HIGH  = 2'd2;
	localparam logic [1:0] MODE_LOW   = 2'd3;

	// Remembered drive direction codes.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_HIGH = 2'd1;
	localparam logic [1:0] DIR_LOW  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_POT_CAL  = 3'd0;
	localparam logic [2:0] CFG_PULSE_WIN = 3'd1;
	localparam logic [2:0] CFG_PERIOD_WIN = 3'd2;
	localparam logic [2:0] CFG_GAIN     = 3'd3;
	localparam logic [2:0] CFG_OFFSET   = 3'd4;
	localparam logic [2:0] CFG_LIMIT    = 3'd5;
	localparam logic [2:0] CFG_DEADBAND = 3'd6;
	localparam logic [2:0] CFG_SLOW     = 3'd7;

	// Serial multiply-divide unit last step indexes.
	localparam logic [4:0] MUL_LAST = 5'd11;
	localparam logic [4:0] DIV_LAST = 5'd23;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD_GO,
		ST_CMD_WAIT,
		ST_GAIN_GO,
		ST_GAIN_WAIT,
		ST_POT_GO,
		ST_POT_WAIT,
		ST_RAMP_GO,
		ST_RAMP_WAIT,
		ST_DONE
	} ctl_state_t;

	// One request to the multiply-divide unit: (a * b + c) / d.
	typedef struct packed {
		logic [11:0] a;
		logic [11:0] b;
		logic [11:0] c;
		logic [11:0] d;
	} md_req_t;

endpackage
`default_nettype wire

// ----- rtl/svpl_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiply-divide unit
// Computes (a * b + c) / d on unsigned operands, one bit per cycle.
// ----------------------------------------------------------------------------
module svpl_muldiv (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire svpl_pkg::md_req_t req,
	output logic                  done,
	output logic [23:0]           quot
);
	import svpl_pkg::*;

	md_state_t   state_q;
	md_state_t   state_d;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [23:0] acc_q;
	logic [23:0] mcand_q;
	logic [11:0] mplier_q;
	logic [11:0] div_q;
	logic [11:0] rem_q;
	logic [12:0] trial;
	logic [12:0] diff;
	logic        fits;

	assign trial = {rem_q, acc_q[23]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: if (start) state_d = MD_MUL;
			MD_MUL:  if (cnt_q == MUL_LAST) state_d = MD_DIV;
			MD_DIV:  if (cnt_q == DIV_LAST) state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q != state_d) ? 5'd0 : cnt_q + 5'd1;
			done_q  <= (state_q == MD_DIV) && (cnt_q == DIV_LAST);
		end
	end

	// Shift-add multiply, LSB of the multiplier first, then restoring divide.
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					acc_q    <= {12'd0, req.c};
					mcand_q  <= {12'd0, req.a};
					mplier_q <= req.b;
					div_q    <= req.d;
					rem_q    <= '0;
				end
			end
			MD_MUL: begin
				acc_q    <= acc_q + (mplier_q[0] ? mcand_q : 24'd0);
				mcand_q  <= {mcand_q[22:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[11:1]};
			end
			MD_DIV: begin
				acc_q <= {acc_q[22:0], fits};
				rem_q <= fits ? diff[11:0] : trial[11:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule
`default_nettype wire

// ----- rtl/servo_position_loop.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position loop
// Bang-bang / proportional position controller for an RC-style servo.
// ----------------------------------------------------------------------------
// Each item makes four passes through the shared bit-serial multiply-divide
// unit; a new item is taken only once the sequencer is idle again.
// Reset clears the registers to their defaults, the held target to zero,
// the remembered direction to none and the stale counter to the timeout.
// ----------------------------------------------------------------------------
module servo_position_loop (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration write port.
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [35:0]        cfg_data,
	// Input channel.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               new_frame,
	input  wire logic [15:0]        pulse_width_us,
	input  wire logic [15:0]        frame_period_us,
	input  wire logic [11:0]        pot_reading,
	// Output channel.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              drive_mode,
	output logic [9:0]              drive_duty,
	output logic signed [11:0]      target_angle,
	output logic signed [11:0]      measured_angle,
	output logic                    signal_ok
);
	import svpl_pkg::*;

	// Configuration registers.
	logic [35:0]        pot_cal_q;
	logic [31:0]        pulse_win_q;
	logic [31:0]        period_win_q;
	logic [11:0]        gain_q;
	logic signed [11:0] offset_q;
	logic [10:0]        limit_q;
	logic [31:0]        deadband_q;
	logic [11:0]        slow_q;

	// Loop state.
	ctl_state_t         state_q;
	ctl_state_t         state_d;
	logic signed [11:0] held_q;
	logic [1:0]         prev_dir_q;
	logic [7:0]         stale_q;

	// Per-item working registers.
	logic               valid_q;
	logic [15:0]        pulse_q;
	logic [11:0]        pot_q;
	logic               cmd_neg_q;
	logic [11:0]        cmd_mag_q;
	logic               pot_div_q;
	logic               pot_ge_q;
	logic signed [11:0] meas_q;
	logic [1:0]         mode_q;
	logic               duty_ramp_q;
	logic               duty_full_q;
	logic [9:0]         duty_q;

	// Output register.
	logic               out_valid_q;
	logic [1:0]         out_mode_q;
	logic [9:0]         out_duty_q;
	logic signed [11:0] out_target_q;
	logic signed [11:0] out_meas_q;
	logic               out_sig_q;

	// Multiply-divide unit hookup.
	logic               md_start;
	md_req_t            md_req;
	logic               md_done;
	logic [23:0]        md_quot;

	logic               accept;
	logic               can_load;

	svpl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.req    (md_req),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Staleness and window checks, evaluated as the item is taken.
	logic [7:0] stale_n;
	logic       valid_n;

	always_comb begin
		if (new_frame) begin
			stale_n = 8'd0;
		end else if (stale_q < STALE_MAX) begin
			stale_n = stale_q + 8'd1;
		end else begin
			stale_n = stale_q;
		end
		valid_n = (pulse_width_us >= pulse_win_q[15:0]) &&
			(pulse_width_us <= pulse_win_q[31:16]) &&
			(frame_period_us >= period_win_q[15:0]) &&
			(frame_period_us <= period_win_q[31:16]) &&
			(stale_n <= TIMEOUT_TICKS);
	end

	// Command path: clamp the pulse and take its distance from center.
	logic [15:0] pulse_clamped;
	logic        pulse_neg;
	logic [15:0] pulse_mag;

	always_comb begin
		if (pulse_q < PULSE_LO_US) begin
			pulse_clamped = PULSE_LO_US;
		end else if (pulse_q > PULSE_HI_US) begin
			pulse_clamped = PULSE_HI_US;
		end else begin
			pulse_clamped = pulse_q;
		end
		pulse_neg = pulse_clamped < PULSE_CENTER_US;
		pulse_mag = pulse_neg ? (PULSE_CENTER_US - pulse_clamped)
			: (pulse_clamped - PULSE_CENTER_US);
	end

	// Gain result: apply sign and offset, then the endpoint limit.
	logic [12:0]        scaled;
	logic signed [14:0] signed_cmd;
	logic signed [14:0] comp;
	logic [10:0]        limit_c;
	logic signed [14:0] lim_pos;
	logic signed [11:0] target_n;

	always_comb begin
		scaled     = md_quot[12:0];
		signed_cmd = cmd_neg_q ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
		comp       = signed_cmd + 15'(offset_q);
		limit_c    = (limit_q > FULL_SCALE[10:0]) ? FULL_SCALE[10:0] : limit_q;
		lim_pos    = $signed({4'b0000, limit_c});
		if (comp > lim_pos) begin
			target_n = 12'(lim_pos);
		end else if (comp < -lim_pos) begin
			target_n = 12'(-lim_pos);
		end else begin
			target_n = 12'(comp);
		end
	end

	// Pot path: pick the side of center and its span.
	logic [11:0]        cal_center;
	logic [11:0]        cal_pos;
	logic [11:0]        cal_neg;
	logic               pot_ge;
	logic [12:0]        pot_span;
	logic [11:0]        pot_dist;
	logic [11:0]        pot_ang;

	always_comb begin
		cal_center = pot_cal_q[11:0];
		cal_pos    = pot_cal_q[23:12];
		cal_neg    = pot_cal_q[35:24];
		pot_ge     = pot_q >= cal_center;
		pot_span   = pot_ge ? ({1'b0, cal_pos} - {1'b0, cal_center})
			: ({1'b0, cal_center} - {1'b0, cal_neg});
		pot_dist   = pot_ge ? (pot_q - cal_center) : (cal_center - pot_q);
		pot_ang    = (md_quot > {12'd0, FULL_SCALE}) ? FULL_SCALE : md_quot[11:0];
	end

	// Error and drive decision.
	logic signed [12:0] err;
	logic [12:0]        err_abs13;
	logic [11:0]        abs_err;
	logic [15:0]        db;
	logic [15:0]        rdb;
	logic [1:0]         req_dir;
	logic [11:0]        ramp_q;

	always_comb begin
		err       = 13'(held_q) - 13'(meas_q);
		err_abs13 = err[12] ? 13'(-err) : 13'(err);
		abs_err   = err_abs13[11:0];
		db        = deadband_q[15:0];
		rdb       = deadband_q[31:16];
		req_dir   = (err > 13'sd0) ? DIR_HIGH : DIR_LOW;
		ramp_q    = (md_quot >= {12'd0, RAMP_SPAN}) ? RAMP_SPAN : md_quot[11:0];
	end

	// Sequencer: next state and unit requests.
	always_comb begin
		state_d  = state_q;
		md_start = 1'b0;
		md_req   = '0;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_CMD_GO;
			ST_CMD_GO: begin
				md_start = 1'b1;
				md_req.a = pulse_mag[11:0];
				md_req.b = FULL_SCALE;
				md_req.c = 12'd0;
				md_req.d = PULSE_HALF_SPAN_US[11:0];
				state_d  = ST_CMD_WAIT;
			end
			ST_CMD_WAIT: if (md_done) state_d = ST_GAIN_GO;
			ST_GAIN_GO: begin
				md_start = 1'b1;
				md_req.a = cmd_mag_q;
				md_req.b = gain_q;
				md_req.c = GAIN_ROUND;
				md_req.d = GAIN_SCALE;
				state_d  = ST_GAIN_WAIT;
			end
			ST_GAIN_WAIT: if (md_done) state_d = ST_POT_GO;
			ST_POT_GO: begin
				md_start = 1'b1;
				md_req.a = pot_dist;
				md_req.b = FULL_SCALE;
				md_req.c = {1'b0, pot_span[11:1]};
				md_req.d = pot_span[11:0];
				state_d  = ST_POT_WAIT;
			end
			ST_POT_WAIT: if (md_done) state_d = ST_RAMP_GO;
			ST_RAMP_GO: begin
				md_start = 1'b1;
				md_req.a = abs_err - db[11:0];
				md_req.b = RAMP_SPAN;
				md_req.c = 12'd0;
				md_req.d = slow_q - db[11:0];
				state_d  = ST_RAMP_WAIT;
			end
			ST_RAMP_WAIT: if (md_done) state_d = ST_DONE;
			ST_DONE: if (can_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, configuration and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			pot_cal_q    <= '0;
			pulse_win_q  <= '0;
			period_win_q <= '0;
			gain_q       <= 12'd1000;
			offset_q     <= '0;
			limit_q      <= 11'd1600;
			deadband_q   <= '0;
			slow_q       <= 12'd100;
			held_q       <= '0;
			prev_dir_q   <= DIR_NONE;
			stale_q      <= TIMEOUT_TICKS;
		end else begin
			state_q <= state_d;

			if (state_q == ST_DONE && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_write) begin
				case (cfg_index)
					CFG_POT_CAL:    pot_cal_q    <= cfg_data;
					CFG_PULSE_WIN:  pulse_win_q  <= cfg_data[31:0];
					CFG_PERIOD_WIN: period_win_q <= cfg_data[31:0];
					CFG_GAIN:       gain_q       <= cfg_data[11:0];
					CFG_OFFSET:     offset_q     <= $signed(cfg_data[11:0]);
					CFG_LIMIT:      limit_q      <= cfg_data[10:0];
					CFG_DEADBAND:   deadband_q   <= cfg_data[31:0];
					CFG_SLOW:       slow_q       <= cfg_data[11:0];
					default: ;
				endcase
			end

			if (accept) begin
				stale_q <= stale_n;
			end

			if (state_q == ST_GAIN_WAIT && md_done && valid_q) begin
				held_q <= target_n;
			end

			// The direction memory follows the drive decision.
			if (state_q == ST_RAMP_GO) begin
				if (!valid_q || {4'd0, abs_err} <= db) begin
					prev_dir_q <= DIR_NONE;
				end else if (!(prev_dir_q != DIR_NONE && req_dir != prev_dir_q &&
						{4'd0, abs_err} < rdb)) begin
					prev_dir_q <= req_dir;
				end
			end
		end
	end

	// Per-item payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			valid_q <= valid_n;
			pulse_q <= pulse_width_us;
			pot_q   <= pot_reading;
		end

		if (state_q == ST_CMD_GO) begin
			cmd_neg_q <= pulse_neg;
		end
		if (state_q == ST_CMD_WAIT && md_done) begin
			cmd_mag_q <= md_quot[11:0];
		end

		// Zero and negative spans are settled without the divider.
		if (state_q == ST_POT_GO) begin
			pot_ge_q  <= pot_ge;
			pot_div_q <= 1'b0;
			if (pot_span == 13'd0) begin
				if (!pot_ge) begin
					meas_q <= -$signed(FULL_SCALE);
				end else if (pot_q > cal_center) begin
					meas_q <= $signed(FULL_SCALE);
				end else begin
					meas_q <= '0;
				end
			end else if (pot_span[12]) begin
				meas_q <= '0;
			end else begin
				pot_div_q <= 1'b1;
			end
		end
		if (state_q == ST_POT_WAIT && md_done && pot_div_q) begin
			meas_q <= pot_ge_q ? $signed(pot_ang) : -$signed(pot_ang);
		end

		if (state_q == ST_RAMP_GO) begin
			duty_ramp_q <= 1'b0;
			duty_full_q <= {4'd0, abs_err} >= 16'(slow_q);
			if (!valid_q) begin
				mode_q <= MODE_COAST;
			end else if ({4'd0, abs_err} <= db) begin
				mode_q <= MODE_BRAKE;
			end else if (prev_dir_q != DIR_NONE && req_dir != prev_dir_q &&
					{4'd0, abs_err} < rdb) begin
				mode_q <= MODE_BRAKE;
			end else begin
				duty_ramp_q <= 1'b1;
				mode_q      <= (req_dir == DIR_HIGH) ? MODE_HIGH : MODE_LOW;
			end
		end
		if (state_q == ST_RAMP_WAIT && md_done) begin
			if (!duty_ramp_q) begin
				duty_q <= '0;
			end else if (duty_full_q) begin
				duty_q <= DUTY_MAX[9:0];
			end else begin
				duty_q <= 10'(MIN_DUTY + ramp_q);
			end
		end

		if (state_q == ST_DONE && can_load) begin
			out_mode_q   <= mode_q;
			out_duty_q   <= duty_q;
			out_target_q <= held_q;
			out_meas_q   <= meas_q;
			out_sig_q    <= valid_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_mode     = out_mode_q;
	assign drive_duty     = out_duty_q;
	assign target_angle   = out_target_q;
	assign measured_angle = out_meas_q;
	assign signal_ok      = out_sig_q;

	// An accepted item always starts the command pass.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CMD_GO)
		else $error("accepted item did not start the command pass");

	// Coast and brake never carry a duty.
	a_idle_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (drive_mode == MODE_COAST || drive_mode == MODE_BRAKE)
		|-> drive_duty == 10'd0)
		else $error("duty present while coasting or braking");

	// An invalid signal always coasts.
	a_invalid_coast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !signal_ok |-> drive_mode == MODE_COAST)
		else $error("invalid signal did not coast");

	// The unit only finishes while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_CMD_WAIT || state_q == ST_GAIN_WAIT ||
			state_q == ST_POT_WAIT || state_q == ST_RAMP_WAIT))
		else $error("multiply-divide result outside a wait state");

endmodule
`default_nettype wire
